@@ src/ctw_pkg.sv @@
// ----------------------------------------------------------------------------
// ctw_pkg
// Shared constants and types for the streaming census transform window.
// ----------------------------------------------------------------------------
`default_nettype none

package ctw_pkg;

	localparam int WINDOW     = 9;
	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;
	localparam int MAX_HEIGHT = 4096;

	localparam int RADIUS   = WINDOW / 2;
	localparam int SPAN     = 2 * RADIUS + 1;
	localparam int LINES    = SPAN - 1;
	localparam int CENTER   = RADIUS * SPAN + RADIUS;
	localparam int NBITS    = SPAN * SPAN - 1;
	localparam int LOW_W    = 64;
	localparam int HIGH_W   = 16;
	localparam int CENSUS_W = LOW_W + HIGH_W;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int OROW_W = $clog2(MAX_HEIGHT);
	localparam int IROW_W = $clog2(MAX_HEIGHT + RADIUS + 3);
	localparam int LAG_W  = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
	localparam int LIM_W  = (RADIUS > 1) ? $clog2(RADIUS + 1) : 1;
	localparam int IDX_W  = $clog2(SPAN);
	localparam int LINE_W = LINES * PIXEL_BITS;

	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int IN_PIX_W  = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam int WIDTH_RESET  = 640;
	localparam int HEIGHT_RESET = 480;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [LINE_W-1:0]     line_t;
	typedef logic [LIM_W-1:0]      lim_t;

	// distances to the frame edges, capped at the radius
	typedef struct packed {
		lim_t top;
		lim_t bot;
		lim_t left;
		lim_t right;
		logic last;
	} edge_info_t;

endpackage

`default_nettype wire

@@ src/ctw_if.sv @@
// ----------------------------------------------------------------------------
// ctw_if
// Valid/ready channels for pixel items in and census results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctw_in_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic [ctw_pkg::IN_PIX_W-1:0]  pixel_value;

	modport source (output valid, output kind, output pixel_value, input ready);
	modport sink   (input valid, input kind, input pixel_value, output ready);
endinterface

interface ctw_out_if;
	logic                        valid;
	logic                        ready;
	logic [ctw_pkg::LOW_W-1:0]   census_low;
	logic [ctw_pkg::HIGH_W-1:0]  census_high;
	logic                        last_of_frame;

	modport source (output valid, output census_low, output census_high,
		output last_of_frame, input ready);
	modport sink   (input valid, input census_low, input census_high,
		input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ src/census_transform_window.sv @@
// Streaming census transform over a square window, one pixel per clock
// unless the result path stalls. Pixels of a frame enter in raster order,
// one transfer per cycle while pixels.ready is high. An accepted pixel or
// drain item that produces a result passes the stage register and then the
// output register before its result is valid. The result for pixel o leaves on
// the item that brings the frame to o + RADIUS*width + RADIUS + 1 items, so
// drain items after the last pixel flush the tail. A line buffer memory of
// MAX_WIDTH entries, each holding one column of the previous WINDOW-1 rows,
// feeds a register window; its single read port is registered and addressed
// with the column of the next pixel. Edge pixels are replicated by steering
// the window taps. Writing either frame register restarts the frame.
// ----------------------------------------------------------------------------
// census_transform_window
// Census vector per pixel with edge clamping, line buffers and a tap window.
// ----------------------------------------------------------------------------
`default_nettype none

module census_transform_window (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ctw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ctw_pkg::CFG_W-1:0]       cfg_data,
	ctw_in_if.sink                          pixels,
	ctw_out_if.source                       census
);

	localparam int P = ctw_pkg::PIXEL_BITS;
	localparam int S = ctw_pkg::SPAN;
	localparam int R = ctw_pkg::RADIUS;

	// frame geometry
	logic [ctw_pkg::WID_W-1:0]  w_q;
	logic [ctw_pkg::HGT_W-1:0]  h_q;
	logic [ctw_pkg::LAG_W-1:0]  lag_q;

	// stream position
	logic [ctw_pkg::COL_W-1:0]  in_col_q, in_col_nx, rd_addr;
	logic [ctw_pkg::IROW_W-1:0] in_row_q;
	logic [ctw_pkg::LAG_W-1:0]  pend_q;
	logic [ctw_pkg::COL_W-1:0]  out_col_q;
	logic [ctw_pkg::OROW_W-1:0] out_row_q;

	logic all_in, in_acc, counted, emit, last_o, restart, cfg_hit, in_wrap, out_wrap;

	// line buffer
	ctw_pkg::line_t lbuf_mem [ctw_pkg::MAX_WIDTH];
	ctw_pkg::line_t lb_rd_q, lb_wd_q, lb_old, lb_wd;
	logic           lb_byp_q;
	ctw_pkg::pixel_t px;

	ctw_pkg::pixel_t win_q [S][S];

	// result pipeline
	logic                    v_s1_q, out_free;
	ctw_pkg::edge_info_t     edge_s1, edge_nx;
	logic [ctw_pkg::CENSUS_W-1:0] cbits;
	logic                    out_v_q;
	logic [ctw_pkg::CENSUS_W-1:0] out_bits_q;
	logic                    out_last_q;

	function automatic ctw_pkg::lim_t cap_lim(input int d);
		ctw_pkg::lim_t r;
		r = (d >= R) ? ctw_pkg::lim_t'(R) : ctw_pkg::lim_t'(d);
		return r;
	endfunction

	assign cfg_hit = cfg_we && (cfg_index == ctw_pkg::REG_FRAME_WIDTH ||
		cfg_index == ctw_pkg::REG_FRAME_HEIGHT);

	assign all_in   = 32'(in_row_q) >= 32'(h_q);
	assign out_free = !out_v_q || census.ready;
	assign pixels.ready = !v_s1_q || out_free;
	assign in_acc   = pixels.valid && pixels.ready;
	// an early drain is taken but has no effect
	assign counted  = in_acc && !(pixels.kind && !all_in);
	assign emit     = counted && (pend_q == lag_q);
	assign last_o   = (32'(out_row_q) == 32'(h_q) - 1) && (32'(out_col_q) == 32'(w_q) - 1);
	assign restart  = emit && last_o;

	assign in_wrap   = (32'(in_col_q) + 1) >= 32'(w_q);
	assign in_col_nx = in_wrap ? '0 : in_col_q + 1'b1;
	assign out_wrap  = (32'(out_col_q) + 1) >= 32'(w_q);

	always_comb begin
		if (restart || cfg_hit) begin
			rd_addr = '0;
		end else if (counted) begin
			rd_addr = in_col_nx;
		end else begin
			rd_addr = in_col_q;
		end
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= ctw_pkg::WID_W'(ctw_pkg::WIDTH_RESET);
			h_q       <= ctw_pkg::HGT_W'(ctw_pkg::HEIGHT_RESET);
			lag_q     <= ctw_pkg::LAG_W'(R * ctw_pkg::WIDTH_RESET + R);
			in_col_q  <= '0;
			in_row_q  <= '0;
			pend_q    <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else begin
			if (cfg_we && cfg_index == ctw_pkg::REG_FRAME_WIDTH) begin
				if (cfg_data[10:0] == '0) begin
					w_q   <= ctw_pkg::WID_W'(1);
					lag_q <= ctw_pkg::LAG_W'(R + R);
				end else if (32'(cfg_data[10:0]) > ctw_pkg::MAX_WIDTH) begin
					w_q   <= ctw_pkg::WID_W'(ctw_pkg::MAX_WIDTH);
					lag_q <= ctw_pkg::LAG_W'(R * ctw_pkg::MAX_WIDTH + R);
				end else begin
					w_q   <= ctw_pkg::WID_W'(cfg_data[10:0]);
					lag_q <= ctw_pkg::LAG_W'(R * 32'(cfg_data[10:0]) + R);
				end
			end
			if (cfg_we && cfg_index == ctw_pkg::REG_FRAME_HEIGHT) begin
				if (cfg_data == '0) begin
					h_q <= ctw_pkg::HGT_W'(1);
				end else if (32'(cfg_data) > ctw_pkg::MAX_HEIGHT) begin
					h_q <= ctw_pkg::HGT_W'(ctw_pkg::MAX_HEIGHT);
				end else begin
					h_q <= ctw_pkg::HGT_W'(cfg_data);
				end
			end
			if (cfg_hit || restart) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				pend_q    <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else if (counted) begin
				in_col_q <= in_col_nx;
				if (in_wrap) begin
					in_row_q <= in_row_q + 1'b1;
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
				end else begin
					pend_q <= pend_q + 1'b1;
				end
			end
		end
	end

	// line buffer: entry x holds column x of the last LINES rows, newest low
	assign px     = ctw_pkg::pixel_t'(pixels.pixel_value);
	assign lb_old = lb_byp_q ? lb_wd_q : lb_rd_q;
	assign lb_wd  = {lb_old[(ctw_pkg::LINES-1)*P-1:0], px};

	always_ff @(posedge clk) begin
		if (counted) begin
			lbuf_mem[in_col_q] <= lb_wd;
		end
		lb_rd_q <= lbuf_mem[rd_addr];
	end

	// read of the address written in the same cycle (one-pixel rows, or a restart at column zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_byp_q <= 1'b0;
		end else begin
			lb_byp_q <= counted && (rd_addr == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		lb_wd_q <= lb_wd;
	end

	// tap window: rightmost column is the newest, bottom row the current line
	always_ff @(posedge clk) begin
		if (counted) begin
			for (int j = 0; j < S; j++) begin
				for (int k = 0; k < S - 1; k++) begin
					win_q[j][k] <= win_q[j][k+1];
				end
				if (j == S - 1) begin
					win_q[j][S-1] <= px;
				end else begin
					win_q[j][S-1] <= lb_old[(S-2-j)*P +: P];
				end
			end
		end
	end

	// edge distances of the pixel whose result is due
	always_comb begin
		edge_nx.top   = cap_lim(int'(out_row_q));
		edge_nx.bot   = cap_lim(int'(h_q) - 1 - int'(out_row_q));
		edge_nx.left  = cap_lim(int'(out_col_q));
		edge_nx.right = cap_lim(int'(w_q) - 1 - int'(out_col_q));
		edge_nx.last  = last_o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (emit) begin
			v_s1_q <= 1'b1;
		end else if (out_free) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			edge_s1 <= edge_nx;
		end
	end

	// census from the window, taps steered onto the nearest in-frame pixel
	always_comb begin
		logic [ctw_pkg::IDX_W-1:0] rsel [S];
		logic [ctw_pkg::IDX_W-1:0] csel [S];
		ctw_pkg::pixel_t nb;
		int b;
		for (int j = 0; j < S; j++) begin
			if (j < R) begin
				rsel[j] = (R - j > int'(edge_s1.top)) ?
					ctw_pkg::IDX_W'(R - int'(edge_s1.top)) : ctw_pkg::IDX_W'(j);
				csel[j] = (R - j > int'(edge_s1.left)) ?
					ctw_pkg::IDX_W'(R - int'(edge_s1.left)) : ctw_pkg::IDX_W'(j);
			end else if (j > R) begin
				rsel[j] = (j - R > int'(edge_s1.bot)) ?
					ctw_pkg::IDX_W'(R + int'(edge_s1.bot)) : ctw_pkg::IDX_W'(j);
				csel[j] = (j - R > int'(edge_s1.right)) ?
					ctw_pkg::IDX_W'(R + int'(edge_s1.right)) : ctw_pkg::IDX_W'(j);
			end else begin
				rsel[j] = ctw_pkg::IDX_W'(j);
				csel[j] = ctw_pkg::IDX_W'(j);
			end
		end
		cbits = '0;
		for (int j = 0; j < S; j++) begin
			for (int k = 0; k < S; k++) begin
				b  = (j * S + k < ctw_pkg::CENTER) ? j * S + k : j * S + k - 1;
				nb = win_q[rsel[j]][csel[k]];
				if (j * S + k != ctw_pkg::CENTER) begin
					cbits[b] = nb > win_q[R][R];
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (v_s1_q && out_free) begin
			out_v_q <= 1'b1;
		end else if (census.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1_q && out_free) begin
			out_bits_q <= cbits;
			out_last_q <= edge_s1.last;
		end
	end

	assign census.valid         = out_v_q;
	assign census.census_low    = out_bits_q[ctw_pkg::LOW_W-1:0];
	assign census.census_high   = out_bits_q[ctw_pkg::CENSUS_W-1:ctw_pkg::LOW_W];
	assign census.last_of_frame = out_last_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= lag_q)
		else $error("pending count exceeds window lag");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(in_col_q) < 32'(w_q)) && (32'(out_col_q) < 32'(w_q)))
		else $error("column counter outside frame");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (pend_q == '0 && in_col_q == '0 && out_row_q == '0))
		else $error("counters not cleared after final result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1_q && out_v_q && !census.ready) |-> !pixels.ready)
		else $error("input taken while result path is full");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixels and drain items into the census window block and
// checks every census vector against a behavioral model in the bench or a fixed expected vector.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int RING = ctw_pkg::WINDOW * ctw_pkg::MAX_WIDTH;

	typedef enum logic [1:0] {ROW_CFG_W, ROW_CFG_H, ROW_ITEM} row_op_t;

	typedef struct packed {
		logic [ctw_pkg::LOW_W-1:0]  low;
		logic [ctw_pkg::HIGH_W-1:0] high;
		logic                       last;
	} census_rec_t;

	typedef struct {
		row_op_t     op;
		logic [12:0] data;
		logic        kind;
		logic [7:0]  pix;
		bit          typed;
		census_rec_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [ctw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ctw_pkg::CFG_W-1:0] cfg_data;

	ctw_in_if  pix_if ();
	ctw_out_if cen_if ();

	census_transform_window DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pixels(pix_if), .census(cen_if)
	);

	// model state
	logic [7:0]  pix_store [RING];
	logic [10:0] reg_width;
	logic [12:0] reg_height;
	int unsigned seen_cnt, out_col, out_row;
	bit          frame_done;

	census_rec_t census_q [$];
	int          err_cnt;
	int          items_sent;
	bit          hold_req;
	bit          calm;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic predict_census(input logic k, input logic [7:0] p, output bit got,
			output census_rec_t r);
		int w, h, total, lag, o, yy, xx, n;
		logic [79:0] cv;
		logic [7:0] c;
		got = 0;
		r = '0;
		w = (reg_width == 0) ? 1 : (reg_width > ctw_pkg::MAX_WIDTH) ? ctw_pkg::MAX_WIDTH :
			int'(reg_width);
		h = (reg_height == 0) ? 1 : (reg_height > ctw_pkg::MAX_HEIGHT) ? ctw_pkg::MAX_HEIGHT :
			int'(reg_height);
		total = w * h;
		lag = ctw_pkg::RADIUS * w + ctw_pkg::RADIUS;
		o = out_row * w + out_col;
		if (seen_cnt < total) begin
			if (k) return;
			pix_store[seen_cnt % RING] = p;
		end
		seen_cnt++;
		if (seen_cnt <= o + lag) return;
		c = pix_store[o % RING];
		cv = '0;
		n = 0;
		for (int dy = -ctw_pkg::RADIUS; dy <= ctw_pkg::RADIUS; dy++)
			for (int dx = -ctw_pkg::RADIUS; dx <= ctw_pkg::RADIUS; dx++) begin
				if (dx == 0 && dy == 0) continue;
				yy = int'(out_row) + dy;
				xx = int'(out_col) + dx;
				yy = (yy < 0) ? 0 : (yy > h - 1) ? h - 1 : yy;
				xx = (xx < 0) ? 0 : (xx > w - 1) ? w - 1 : xx;
				if (pix_store[(yy * w + xx) % RING] > c) cv[n] = 1'b1;
				n++;
			end
		got = 1;
		r.low = cv[63:0];
		r.high = cv[79:64];
		r.last = (o >= total - 1);
		if (r.last) begin
			seen_cnt = 0; out_col = 0; out_row = 0;
			frame_done = 1;
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	// stop offering before waiting, so the held item is not taken again
	task automatic wait_idle();
		@(negedge clk);
		pix_if.valid <= 1'b0;
		wait (census_q.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [ctw_pkg::CFG_IDX_W-1:0] idx,
			input logic [12:0] val);
		wait_idle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == ctw_pkg::REG_FRAME_WIDTH) reg_width = val[10:0];
		else reg_height = val;
		seen_cnt = 0; out_col = 0; out_row = 0;
		frame_done = 0;
	endtask

	// one transfer on the pixel channel, sometimes with a random gap in front
	task automatic send_item(input logic k, input logic [7:0] p, input bit typed,
			input census_rec_t typed_res);
		bit got;
		census_rec_t r;
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			pix_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.kind <= k;
		pix_if.pixel_value <= p;
		do @(posedge clk); while (!pix_if.ready);
		predict_census(k, p, got, r);
		items_sent++;
		if (got) census_q.push_back(typed ? typed_res : r);
	endtask

	task automatic drain_frame();
		while (!frame_done) begin
			// a surplus pixel now and then stands in for a drain item
			if ($urandom_range(0, 7) == 0) send_item(1'b0, 8'($urandom), 1'b0, '0);
			else send_item(1'b1, 8'($urandom), 1'b0, '0);
		end
	endtask

	task automatic run_frame(input int w, input int h, input bit noisy, input bit abandon);
		int total, stop_at;
		logic [7:0] p;
		write_reg(ctw_pkg::REG_FRAME_WIDTH, 13'(w));
		write_reg(ctw_pkg::REG_FRAME_HEIGHT, 13'(h));
		calm = ($urandom_range(0, 3) == 0);
		total = ((w == 0) ? 1 : (w > ctw_pkg::MAX_WIDTH) ? ctw_pkg::MAX_WIDTH : w)
			* ((h == 0) ? 1 : (h > ctw_pkg::MAX_HEIGHT) ? ctw_pkg::MAX_HEIGHT : h);
		stop_at = abandon ? $urandom_range(0, (total < 200) ? total : 200) : total;
		for (int i = 0; i < stop_at; i++) begin
			if (noisy && $urandom_range(0, 15) == 0)
				send_item(1'b1, 8'($urandom), 1'b0, '0);
			case ($urandom_range(0, 9))
				0: p = 8'h00;
				1: p = 8'hFF;
				2: p = 8'h80;
				default: p = 8'($urandom);
			endcase
			send_item(1'b0, p, 1'b0, '0);
		end
		if (!abandon) drain_frame();
	endtask

	stim_row_t dir_rows [$];

	task automatic add_row(input row_op_t op, input logic [12:0] data, input logic k,
			input logic [7:0] p, input bit typed, input census_rec_t res);
		stim_row_t s;
		s.op = op; s.data = data; s.kind = k; s.pix = p; s.typed = typed; s.res = res;
		dir_rows.push_back(s);
	endtask

	initial begin
		census_rec_t none;
		none = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_if.valid = 1'b0;
		pix_if.kind = 1'b0;
		pix_if.pixel_value = '0;
		reg_width = 11'(ctw_pkg::WIDTH_RESET);
		reg_height = 13'(ctw_pkg::HEIGHT_RESET);
		seen_cnt = 0; out_col = 0; out_row = 0;
		frame_done = 0; err_cnt = 0; items_sent = 0; hold_req = 0; calm = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 1x1 frame: early drain ignored, surplus pixel acts as drain,
		// all taps clamp to the lone pixel so the vector is zero
		add_row(ROW_CFG_W, 13'd1, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_CFG_H, 13'd1, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b1, 8'h00, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'hFF, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h00, 1'b0, none);
		for (int i = 0; i < 6; i++) add_row(ROW_ITEM, 13'd0, 1'b1, 8'h55, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b1, 8'hAA, 1'b1, '{low: '0, high: '0, last: 1'b1});
		// 3x3 frame with extreme values, checked against the model
		add_row(ROW_CFG_W, 13'd3, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_CFG_H, 13'd3, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'hFF, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h01, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'hFE, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h80, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h7F, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'hFF, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h00, 1'b0, none);
		add_row(ROW_ITEM, 13'd0, 1'b0, 8'h80, 1'b0, none);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].op)
				ROW_CFG_W: write_reg(ctw_pkg::REG_FRAME_WIDTH, dir_rows[i].data);
				ROW_CFG_H: write_reg(ctw_pkg::REG_FRAME_HEIGHT, dir_rows[i].data);
				default: send_item(dir_rows[i].kind, dir_rows[i].pix, dir_rows[i].typed,
					dir_rows[i].res);
			endcase
		end
		drain_frame();

		// register extremes, out-of-range values included
		run_frame(1024, 1, 0, 1);
		run_frame(0, 0, 1, 0);
		run_frame(2047, 2, 0, 1);
		run_frame(1, 8191, 0, 1);
		run_frame(1, 64, 1, 0);
		// receiver holds off long while the sender keeps offering
		wait_idle();
		hold_req = 1;
		run_frame(16, 16, 0, 0);

		while (items_sent < 1550) begin
			if ($urandom_range(0, 9) == 0)
				run_frame($urandom_range(0, 2047), $urandom_range(0, 3), 1, 1);
			else if ($urandom_range(0, 7) == 0)
				run_frame($urandom_range(20, 40), $urandom_range(1, 12), 1, 0);
			else
				run_frame($urandom_range(1, 12), $urandom_range(1, 10),
					$urandom_range(0, 2) == 0, 0);
		end

		@(negedge clk);
		pix_if.valid <= 1'b0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side readiness
	initial begin
		cen_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				cen_if.ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				cen_if.ready <= 1'b0;
				if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 60)) @(negedge clk);
				else repeat ($urandom_range(1, 3)) @(negedge clk);
			end else begin
				cen_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		census_rec_t want;
		if (arst_n && cen_if.valid && cen_if.ready) begin
			if (census_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10) $display("unexpected census transfer %h_%h last %b",
					cen_if.census_high, cen_if.census_low, cen_if.last_of_frame);
			end else begin
				want = census_q.pop_front();
				if (want.low !== cen_if.census_low || want.high !== cen_if.census_high
						|| want.last !== cen_if.last_of_frame) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("census mismatch: exp %h_%h last %b, got %h_%h last %b",
							want.high, want.low, want.last, cen_if.census_high,
							cen_if.census_low, cen_if.last_of_frame);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ filelist.f @@
src/ctw_pkg.sv
src/ctw_if.sv
src/census_transform_window.sv
tb/tb_top.sv
